>>> sv/nur_replacement_policy_macros.svh
// Assertion macros for the NUR replacement policy block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef NUR_REPLACEMENT_POLICY_MACROS_SVH
`define NUR_REPLACEMENT_POLICY_MACROS_SVH
`ifndef SYNTHESIS
// Overlapping implication, checked on every rising edge outside reset.
`define NUR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nur_replacement_policy: check failed");
// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define NUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nur_replacement_policy: check failed");
`else
`define NUR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NUR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/nur_pkg.sv
// Shared types and constants of the NUR replacement policy block.
// Used by nur_ctrl and the top level nur_replacement_policy.
package nur_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int CNT_W          = 16;
	localparam int IDX_W          = 4;
	localparam logic [CNT_W-1:0] THR_RESET = 16'd8;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_REPLACE = 2'd2,
		CMD_INVAL   = 2'd3
	} cmd_t;

	// One word of the block state memory.
	typedef struct packed {
		logic valid;
		logic referenced;
		logic modified;
	} entry_t;

	typedef struct packed {
		logic             deref_done;
		logic             victim_was_modified;
		logic [IDX_W-1:0] victim_index;
	} res_t;

endpackage

>>> sv/nur_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/nur_ctrl.sv
// Sequencer of the NUR replacement policy: access counter, clear flags,
// read-modify-write of the block state memory, victim scan and result register.
// Depends on nur_pkg and nur_replacement_policy_macros.svh.
`include "nur_replacement_policy_macros.svh"
module nur_ctrl
	import nur_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int AW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
	localparam int PW        = $clog2(NUM_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             in_cmd,
	input  logic [IDX_W-1:0] in_idx,
	input  logic [CNT_W-1:0] thr,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res,
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output entry_t           ram_wdata,
	output logic             ram_re,
	output logic [AW-1:0]    ram_raddr,
	input  entry_t           ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_SCAN,
		S_VWR,
		S_RES
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	// A set flag means the memory copy of that bit is stale and reads as zero.
	logic [NUM_BLOCKS-1:0] ref_clr_q;
	logic [NUM_BLOCKS-1:0] val_clr_q;
	logic [NUM_BLOCKS-1:0] mod_clr_q;
	cmd_t                cmd_q;
	logic [AW-1:0]       acc_addr_q;
	logic                acc_hit_q;
	logic [PW-1:0]       ptr_q;
	logic                rvalid_s1;
	logic [AW-1:0]       raddr_s1;
	logic                found_inv_q;
	logic [AW-1:0]       inv_idx_q;
	logic                inv_ref_q;
	logic [2:0]          best_cls_q;
	logic [AW-1:0]       best_idx_q;
	logic                best_ref_q;
	logic                best_mod_q;
	res_t                res_q;
	logic                out_valid_q;
	res_t                out_res_q;

	logic             accept;
	logic             is_access;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] chk_val;
	logic             chk_hit;
	logic             idx_ok;
	entry_t           rd_eff;
	logic [1:0]       rd_cls;
	logic             scan_last;
	logic [AW-1:0]    vic_idx;
	logic             vic_ref;
	logic             out_free;
	logic             out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_access = (in_cmd == CMD_READ) || (in_cmd == CMD_WRITE);
	assign cnt_inc   = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign chk_val   = (in_cmd == CMD_INVAL) ? cnt_q : cnt_inc;
	assign chk_hit   = (chk_val >= thr);
	assign idx_ok    = (32'(in_idx) < NUM_BLOCKS);
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == S_RES) && out_free;

	always_comb begin
		rd_eff.valid      = ram_rdata.valid && !val_clr_q[raddr_s1];
		rd_eff.referenced = ram_rdata.referenced && !ref_clr_q[raddr_s1];
		rd_eff.modified   = ram_rdata.modified && !mod_clr_q[raddr_s1];
	end

	assign rd_cls    = {rd_eff.referenced, rd_eff.modified};
	assign scan_last = rvalid_s1 && (raddr_s1 == AW'(NUM_BLOCKS - 1));
	assign vic_idx   = found_inv_q ? inv_idx_q : best_idx_q;
	assign vic_ref   = found_inv_q ? inv_ref_q : best_ref_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (accept && in_cmd != CMD_INVAL) begin
			ram_re    = 1'b1;
			ram_raddr = (in_cmd == CMD_REPLACE) ? '0 : AW'(in_idx);
		end else if (state_q == S_SCAN && ptr_q < PW'(NUM_BLOCKS)) begin
			ram_re    = 1'b1;
			ram_raddr = ptr_q[AW-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = acc_addr_q;
		ram_wdata = '{valid: rd_eff.valid, referenced: 1'b1,
			modified: rd_eff.modified || (cmd_q == CMD_WRITE)};
		case (state_q)
			S_ACC: begin
				ram_we = acc_hit_q;
			end
			S_VWR: begin
				ram_we    = 1'b1;
				ram_waddr = vic_idx;
				ram_wdata = '{valid: 1'b1, referenced: vic_ref, modified: 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ref_clr_q   <= '1;
			val_clr_q   <= '1;
			mod_clr_q   <= '1;
			cmd_q       <= CMD_READ;
			acc_addr_q  <= '0;
			acc_hit_q   <= 1'b0;
			ptr_q       <= '0;
			rvalid_s1   <= 1'b0;
			raddr_s1    <= '0;
			found_inv_q <= 1'b0;
			inv_idx_q   <= '0;
			inv_ref_q   <= 1'b0;
			best_cls_q  <= 3'd4;
			best_idx_q  <= '0;
			best_ref_q  <= 1'b0;
			best_mod_q  <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			rvalid_s1 <= ram_re;
			raddr_s1  <= ram_raddr;
			if (out_load) begin
				out_res_q   <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				ref_clr_q[ram_waddr] <= 1'b0;
				val_clr_q[ram_waddr] <= 1'b0;
				mod_clr_q[ram_waddr] <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= in_cmd;
						acc_addr_q <= AW'(in_idx);
						acc_hit_q  <= idx_ok;
						if (is_access) begin
							cnt_q <= chk_hit ? '0 : cnt_inc;
							res_q <= '{deref_done: chk_hit, victim_was_modified: 1'b0,
								victim_index: '0};
							if (chk_hit) begin
								ref_clr_q <= '1;
							end
							state_q <= S_ACC;
						end else if (in_cmd == CMD_REPLACE) begin
							res_q       <= '0;
							ptr_q       <= PW'(1);
							found_inv_q <= 1'b0;
							best_cls_q  <= 3'd4;
							state_q     <= S_SCAN;
						end else begin
							val_clr_q <= '1;
							res_q     <= '{deref_done: chk_hit, victim_was_modified: 1'b0,
								victim_index: '0};
							if (chk_hit) begin
								cnt_q     <= '0;
								ref_clr_q <= '1;
							end
							state_q <= S_RES;
						end
					end
				end
				S_ACC: begin
					state_q <= S_RES;
				end
				S_SCAN: begin
					if (ram_re) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rvalid_s1) begin
						if (!rd_eff.valid) begin
							if (!found_inv_q) begin
								found_inv_q <= 1'b1;
								inv_idx_q   <= raddr_s1;
								inv_ref_q   <= rd_eff.referenced;
							end
						end else if ({1'b0, rd_cls} < best_cls_q) begin
							best_cls_q <= {1'b0, rd_cls};
							best_idx_q <= raddr_s1;
							best_ref_q <= rd_eff.referenced;
							best_mod_q <= rd_eff.modified;
						end
					end
					if (scan_last) begin
						state_q <= S_VWR;
					end
				end
				S_VWR: begin
					res_q   <= '{deref_done: 1'b0,
						victim_was_modified: !found_inv_q && best_mod_q,
						victim_index: IDX_W'(vic_idx)};
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`NUR_ASSERT_IMP(a_we_state, clk, arst_n, ram_we, state_q == S_ACC || state_q == S_VWR)
	`NUR_ASSERT_NEXT(a_replace_scan, clk, arst_n, accept && in_cmd == CMD_REPLACE, state_q == S_SCAN)
	`NUR_ASSERT_IMP(a_out_load, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_RES)
	`NUR_ASSERT_IMP(a_done_no_wb, clk, arst_n, out_valid_q && out_res_q.deref_done, !out_res_q.victim_was_modified)

endmodule

>>> sv/nur_replacement_policy.sv
// Channel   | Dir | Contents
// s_axis    | in  | tuser[1:0] command; tdata[3:0] block_index
// m_axis    | out | tdata[3:0] victim_index, [4] victim_was_modified, [5] deref_done
// cfg       | in  | cfg_we / cfg_wdata write deref_threshold
//
// A read or write passes through a memory read, the write-back in S_ACC and the result
// stage S_RES; invalidate goes straight to S_RES. A replace runs a scan that reads the
// state memory one block per cycle through its single read port, then S_VWR and S_RES.
// One item is in flight at a time; the result register lets the next item in while a
// result waits for m_axis_tready. Reset needs no clearing pass: per-block stale flags
// make every block read as invalid, unreferenced and unmodified until it is written.
// Top level of the NUR replacement policy; depends on nur_pkg, nur_ctrl and nur_ram.
module nur_replacement_policy
	import nur_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [3:0] block_index, [7:4] zero
	input  logic [1:0]       s_axis_tuser,  // [1:0] command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [3:0] victim_index, [4] victim_was_modified,
	                                        // [5] deref_done, [7:6] zero
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	logic [CNT_W-1:0] thr_q;
	res_t             res;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	entry_t           ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	nur_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (cmd_t'(s_axis_tuser)),
		.in_idx    (s_axis_tdata[IDX_W-1:0]),
		.thr       (thr_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	nur_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tdata = {2'b00, res.deref_done, res.victim_was_modified, res.victim_index};

endmodule
